### rtl/incircle_tolerance_predicate_top_assert.svh
// Assertion macros for the incircle predicate block.
// Expanded inside a module that has clk and rst_n in scope.
`ifndef INCIRCLE_TOLERANCE_PREDICATE_TOP_ASSERT_SVH
`define INCIRCLE_TOLERANCE_PREDICATE_TOP_ASSERT_SVH

// same-cycle implication
`define ITP_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ITP_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/itp_pkg.sv
// Package for the incircle predicate block: widths, reset values, codes, types.
// No dependencies.
package itp_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IN_FIELDS   = 8;
  localparam int NPT         = 6;
  localparam int IN_TDATA_W  = IN_FIELDS * COORD_W;
  localparam int SIDE_W      = 2;
  localparam int OUT_TDATA_W = 8;

  localparam int TM_W        = 16;
  localparam int TS_W        = 7;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [TM_W-1:0] TM_RST = TM_W'(1153);
  localparam logic [TS_W-1:0] TS_RST = TS_W'(70);

  // datapath widths
  localparam int DW    = COORD_W + 1;
  localparam int PW    = 2 * DW;
  localparam int SW    = PW + 1;
  localparam int LO_W  = (SW + 1) / 2;
  localparam int HI_W  = SW - LO_W;
  localparam int PPW   = 2 * (LO_W + 1);
  localparam int TW    = 2 * SW;
  localparam int DETW  = TW + 2;
  localparam int MW    = DW;
  localparam int M2W   = 2 * MW;
  localparam int M4W   = 2 * M2W;
  localparam int NCH   = 4;
  localparam int CHW   = M4W / NCH;
  localparam int TCW   = CHW + TM_W;
  localparam int TPW   = M4W + TM_W;
  localparam int CMPW  = TPW + 2;
  localparam int NST   = 10;

  localparam logic [MW-1:0] M_FLOOR = MW'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL_MULT  = CFG_IDX_W'(0),
    CFG_TOL_SHIFT = CFG_IDX_W'(1)
  } cfg_idx_t;

  typedef enum logic [SIDE_W-1:0] {
    SIDE_ON  = 2'b00,
    SIDE_IN  = 2'b01,
    SIDE_OUT = 2'b11
  } side_t;

  typedef logic signed [DW-1:0]   diff_t;
  typedef logic        [MW-1:0]   mag_t;
  typedef logic signed [PW-1:0]   prod_t;
  typedef logic        [SW-1:0]   sq_t;
  typedef logic signed [SW-1:0]   cr_t;
  typedef logic signed [PPW-1:0]  pp_t;
  typedef logic signed [TW-1:0]   term_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic        [M2W-1:0]  m2_t;
  typedef logic        [M4W-1:0]  m4_t;
  typedef logic        [TCW-1:0]  tpart_t;
  typedef logic        [TPW-1:0]  tol_t;

endpackage

### rtl/incircle_tolerance_predicate_top.sv
// Incircle predicate with scaled tolerance, ten-stage pipeline.
// Depends on itp_pkg and incircle_tolerance_predicate_top_assert.svh.
//
//  channel | ports                              | carries
//  in      | in_tvalid  in_tready  in_tdata     | a, b, c, query coordinates
//  out     | out_tvalid out_tready out_tdata    | side
//  cfg     | cfg_valid  cfg_ready  cfg_index/data | tol_mult, tol_shift
//
// One request per cycle while the output is not stalled.
// Depth is set by the 134-bit determinant products, each cut into
// four partial products and summed in the following stage.
// rst_n clears the stage valids and loads the tolerance defaults.
// A stalled output holds its stage; upstream bubbles still close up.
`include "incircle_tolerance_predicate_top_assert.svh"

module incircle_tolerance_predicate_top
  import itp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y, query_x, query_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // side [1:0], zeros above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TM_W-1:0] tol_mult_r;
  logic [TS_W-1:0] tol_shift_r;

  logic [NST-1:0] vld_r, vld_nxt, en;
  logic           in_acc;

  diff_t  diff_r [NPT], diff_nxt [NPT];
  prod_t  prod_r [12],  prod_nxt [12];
  mag_t   mag_r  [NPT], mag_nxt  [NPT];
  sq_t    sq_r   [3],   sq_nxt   [3];
  cr_t    cr_r   [3],   cr_nxt   [3];
  mag_t   m_r,          m_nxt;
  pp_t    pp_r   [3][4], pp_nxt  [3][4];
  m2_t    msq_r,        msq_nxt;
  term_t  trm_r  [3],   trm_nxt  [3];
  m2_t    q_r    [3],   q_nxt    [3];
  det_t   det_r,        det_nxt;
  m4_t    m4_r,         m4_nxt;
  det_t   det7_r, det8_r, det9_r;
  tpart_t tp_r   [NCH], tp_nxt   [NCH];
  tol_t   tprod_r,      tprod_nxt;
  tol_t   tol_r,        tol_nxt;
  side_t  side_r,       side_nxt;
  logic   cmp_gt, cmp_lt;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_mult_r  <= TM_RST;
      tol_shift_r <= TS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOL_MULT:  tol_mult_r  <= cfg_data[TM_W-1:0];
        CFG_TOL_SHIFT: tol_shift_r <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or everything after it moves
  for (genvar g = 0; g < NST; g++) begin : g_en
    assign en[g] = out_tready || !(&vld_r[NST-1:g]);
  end

  assign in_tready  = en[0];
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = {{(OUT_TDATA_W-SIDE_W){1'b0}}, side_r};

  always_comb begin
    vld_nxt[0] = en[0] ? in_acc : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: translate by query point
  always_comb begin
    logic signed [COORD_W-1:0] pt, rf;
    for (int i = 0; i < NPT; i++) begin
      pt = in_tdata[i*COORD_W +: COORD_W];
      rf = i[0] ? in_tdata[(NPT+1)*COORD_W +: COORD_W] : in_tdata[NPT*COORD_W +: COORD_W];
      diff_nxt[i] = DW'(pt) - DW'(rf);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff_r <= diff_nxt;
    end
  end

  // stage 2: squares, cross products, magnitudes
  always_comb begin
    prod_nxt[0]  = diff_r[0] * diff_r[0];
    prod_nxt[1]  = diff_r[1] * diff_r[1];
    prod_nxt[2]  = diff_r[2] * diff_r[2];
    prod_nxt[3]  = diff_r[3] * diff_r[3];
    prod_nxt[4]  = diff_r[4] * diff_r[4];
    prod_nxt[5]  = diff_r[5] * diff_r[5];
    prod_nxt[6]  = diff_r[2] * diff_r[5];
    prod_nxt[7]  = diff_r[3] * diff_r[4];
    prod_nxt[8]  = diff_r[0] * diff_r[5];
    prod_nxt[9]  = diff_r[1] * diff_r[4];
    prod_nxt[10] = diff_r[0] * diff_r[3];
    prod_nxt[11] = diff_r[1] * diff_r[2];
    for (int i = 0; i < NPT; i++) begin
      mag_nxt[i] = diff_r[i][DW-1] ? mag_t'(-diff_r[i]) : mag_t'(diff_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_r <= prod_nxt;
      mag_r  <= mag_nxt;
    end
  end

  // stage 3: lifted norms, 2x2 minors, max difference
  always_comb begin
    mag_t mx;
    for (int j = 0; j < 3; j++) begin
      sq_nxt[j] = {1'b0, prod_r[2*j]} + {1'b0, prod_r[2*j+1]};
      cr_nxt[j] = SW'(prod_r[6+2*j]) - SW'(prod_r[7+2*j]);
    end
    mx = M_FLOOR;
    for (int i = 0; i < NPT; i++) begin
      if (mag_r[i] > mx) begin
        mx = mag_r[i];
      end
    end
    m_nxt = mx;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq_r <= sq_nxt;
      cr_r <= cr_nxt;
      m_r  <= m_nxt;
    end
  end

  // stage 4: partial products of norm * minor, m squared
  always_comb begin
    logic signed [LO_W:0]   al_s, cl_s;
    logic signed [HI_W:0]   ah_s;
    logic signed [HI_W-1:0] ch_s;
    for (int j = 0; j < 3; j++) begin
      al_s = $signed({1'b0, sq_r[j][LO_W-1:0]});
      ah_s = $signed({1'b0, sq_r[j][SW-1:LO_W]});
      cl_s = $signed({1'b0, cr_r[j][LO_W-1:0]});
      ch_s = cr_r[j][SW-1:LO_W];
      pp_nxt[j][0] = al_s * cl_s;
      pp_nxt[j][1] = al_s * ch_s;
      pp_nxt[j][2] = ah_s * cl_s;
      pp_nxt[j][3] = ah_s * ch_s;
    end
    msq_nxt = m_r * m_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pp_r  <= pp_nxt;
      msq_r <= msq_nxt;
    end
  end

  // stage 5: sum partials into the three terms; partials of m^4
  always_comb begin
    logic [MW-1:0] ml, mh;
    for (int j = 0; j < 3; j++) begin
      trm_nxt[j] = TW'(pp_r[j][0])
                 + ((TW'(pp_r[j][1]) + TW'(pp_r[j][2])) <<< LO_W)
                 + (TW'(pp_r[j][3]) <<< (2*LO_W));
    end
    ml = msq_r[MW-1:0];
    mh = msq_r[M2W-1:MW];
    q_nxt[0] = ml * ml;
    q_nxt[1] = ml * mh;
    q_nxt[2] = mh * mh;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      trm_r <= trm_nxt;
      q_r   <= q_nxt;
    end
  end

  // stage 6: determinant and m^4
  always_comb begin
    det_nxt = DETW'(trm_r[0]) - DETW'(trm_r[1]) + DETW'(trm_r[2]);
    m4_nxt  = M4W'(q_r[0]) + (M4W'(q_r[1]) << (MW+1)) + (M4W'(q_r[2]) << (2*MW));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      det_r <= det_nxt;
      m4_r  <= m4_nxt;
    end
  end

  // stage 7: m^4 * tol_mult in chunks
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      tp_nxt[k] = m4_r[k*CHW +: CHW] * tol_mult_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      tp_r   <= tp_nxt;
      det7_r <= det_r;
    end
  end

  // stage 8: tolerance product
  always_comb begin
    tprod_nxt = '0;
    for (int k = 0; k < NCH; k++) begin
      tprod_nxt = tprod_nxt + (TPW'(tp_r[k]) << (k*CHW));
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tprod_r <= tprod_nxt;
      det8_r  <= det7_r;
    end
  end

  // stage 9: scale tolerance
  assign tol_nxt = tprod_r >> tol_shift_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      tol_r  <= tol_nxt;
      det9_r <= det8_r;
    end
  end

  // stage 10: classify against +/- tolerance
  always_comb begin
    logic signed [CMPW-1:0] det_e, tol_e, dm, dp;
    det_e  = CMPW'(det9_r);
    tol_e  = $signed(CMPW'(tol_r));
    dm     = det_e - tol_e;
    dp     = det_e + tol_e;
    cmp_gt = !dm[CMPW-1] && (dm != '0);
    cmp_lt = dp[CMPW-1];
    if (cmp_gt) begin
      side_nxt = SIDE_IN;
    end else if (cmp_lt) begin
      side_nxt = SIDE_OUT;
    end else begin
      side_nxt = SIDE_ON;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      side_r <= side_nxt;
    end
  end

  `ITP_ASSERT_IMP(a_side_excl, vld_r[NST-2], !(cmp_gt && cmp_lt), "inside and outside both set")
  `ITP_ASSERT_NXT(a_accept_enters, in_acc, vld_r[0], "accepted request not in stage 1")
  `ITP_ASSERT_IMP(a_full_stall, (&vld_r) && !out_tready, !in_tready, "input taken while full")
  `ITP_ASSERT_NXT(a_last_moves, vld_r[NST-2] && en[NST-1], vld_r[NST-1], "result lost at output")

endmodule
